// ===== rtl/core/line_rasterizer_defines.svh =====
// ----------------------------------------------------------------------------
// Line rasterizer assertion macros
// Shared concurrent assertion forms for the line rasterizer checkers.
// ----------------------------------------------------------------------------
`ifndef LINE_RASTERIZER_DEFINES_SVH
`define LINE_RASTERIZER_DEFINES_SVH

// Assertion that is switched off while reset is high.
`define LRAS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is also evaluated at reset edges.
`define LRAS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/lras_pkg.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer package
// Widths, register codes, payload and internal job types of the rasterizer.
// ----------------------------------------------------------------------------
package lras_pkg;

  localparam int COORD_BITS   = 12;
  localparam int DIM_BITS     = 7;
  localparam int PIX_BITS     = 6;
  localparam int ERR_BITS     = COORD_BITS + 2;
  localparam int CFG_IDX_BITS = 1;

  localparam logic [DIM_BITS-1:0] CANVAS_MAX   = DIM_BITS'(64);
  localparam logic [DIM_BITS-1:0] WIDTH_RESET  = DIM_BITS'(60);
  localparam logic [DIM_BITS-1:0] HEIGHT_RESET = DIM_BITS'(30);

  // Queue depths are powers of two so that the pointers wrap naturally.
  localparam int JOB_DEPTH    = 2;
  localparam int JOB_PTR_BITS = $clog2(JOB_DEPTH);
  localparam int JOB_CNT_BITS = $clog2(JOB_DEPTH + 1);
  localparam int OUT_DEPTH    = 4;
  localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CANVAS_WIDTH,
    REG_CANVAS_HEIGHT
  } cfg_reg_t;

  typedef enum logic [1:0] {
    WALK_IDLE,
    WALK_STEP,
    WALK_FLUSH
  } walk_state_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
  } line_cmd_t;

  typedef struct packed {
    logic [PIX_BITS-1:0] pixel_x;
    logic [PIX_BITS-1:0] pixel_y;
    logic                last_pixel;
  } pixel_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COORD_BITS-1:0]        abs_dx;
    logic [COORD_BITS-1:0]        abs_dy;
    logic                         x_down;
    logic                         y_down;
    logic signed [ERR_BITS-1:0]   err;
  } walk_job_t;

  typedef struct packed {
    logic [DIM_BITS-1:0] width;
    logic [DIM_BITS-1:0] height;
  } canvas_t;

endpackage

// ===== rtl/core/lras_front.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer front end
// Accepts line commands, works out spans, step directions and the initial
// error term, and queues the resulting walk jobs for the back end.
// ----------------------------------------------------------------------------
module lras_front import lras_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  line_cmd_t command,
  output logic      job_valid,
  input  logic      job_take,
  output walk_job_t job
);

  logic signed [COORD_BITS:0] dx_s;
  logic signed [COORD_BITS:0] dy_s;
  logic signed [COORD_BITS:0] dx_abs;
  logic signed [COORD_BITS:0] dy_abs;
  walk_job_t                  job_in;

  walk_job_t                  job_q [JOB_DEPTH];
  logic [JOB_PTR_BITS-1:0]    wr_ptr;
  logic [JOB_PTR_BITS-1:0]    rd_ptr;
  logic [JOB_CNT_BITS-1:0]    count;
  logic                       wr_en;
  logic                       rd_en;

  always_comb begin
    dx_s   = {command.end_x[COORD_BITS-1], command.end_x}
           - {command.start_x[COORD_BITS-1], command.start_x};
    dy_s   = {command.end_y[COORD_BITS-1], command.end_y}
           - {command.start_y[COORD_BITS-1], command.start_y};
    dx_abs = dx_s[COORD_BITS] ? -dx_s : dx_s;
    dy_abs = dy_s[COORD_BITS] ? -dy_s : dy_s;

    job_in.start_x = command.start_x;
    job_in.start_y = command.start_y;
    job_in.end_x   = command.end_x;
    job_in.end_y   = command.end_y;
    job_in.abs_dx  = dx_abs[COORD_BITS-1:0];
    job_in.abs_dy  = dy_abs[COORD_BITS-1:0];
    // A walk steps down unless the end lies strictly above the start.
    job_in.x_down  = (dx_s <= 0);
    job_in.y_down  = (dy_s <= 0);
    job_in.err     = $signed({2'b00, dx_abs[COORD_BITS-1:0]})
                   - $signed({2'b00, dy_abs[COORD_BITS-1:0]});
  end

  assign full      = (count == JOB_CNT_BITS'(JOB_DEPTH));
  assign job_valid = (count != '0);
  assign job       = job_q[rd_ptr];
  assign wr_en     = push && !full;
  assign rd_en     = job_take && job_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + JOB_PTR_BITS'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + JOB_PTR_BITS'(1);
      end
      count <= count + JOB_CNT_BITS'(wr_en) - JOB_CNT_BITS'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      job_q[wr_ptr] <= job_in;
    end
  end

endmodule

// ===== rtl/core/lras_walker.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer back end
// Walks one queued line a step per cycle while the result queue has room,
// filters points against the canvas and places pixels into the result queue,
// flagging the final one.
module lras_walker import lras_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  canvas_t   canvas,
  input  logic      job_valid,
  output logic      job_take,
  input  walk_job_t job,
  output logic      empty,
  input  logic      pop,
  output pixel_t    pixel
);

  walk_state_t                  state;
  walk_state_t                  state_next;

  logic signed [COORD_BITS-1:0] cur_x;
  logic signed [COORD_BITS-1:0] cur_y;
  logic signed [COORD_BITS-1:0] end_x;
  logic signed [COORD_BITS-1:0] end_y;
  logic [COORD_BITS-1:0]        abs_dx;
  logic [COORD_BITS-1:0]        abs_dy;
  logic                         x_down;
  logic                         y_down;
  logic signed [ERR_BITS-1:0]   err;
  logic                         held_valid;
  logic [PIX_BITS-1:0]          held_x;
  logic [PIX_BITS-1:0]          held_y;

  logic                         on_canvas;
  logic                         at_end;
  logic signed [ERR_BITS:0]     e2;
  logic signed [ERR_BITS:0]     dx_e;
  logic signed [ERR_BITS:0]     dy_e;
  logic                         move_x;
  logic                         move_y;
  logic signed [ERR_BITS:0]     err_sum;

  logic                         do_load;
  logic                         do_step;
  logic                         held_set;
  logic                         held_clear;
  logic                         out_push;
  pixel_t                       out_data;

  pixel_t                       out_q [OUT_DEPTH];
  logic [OUT_PTR_BITS-1:0]      wr_ptr;
  logic [OUT_PTR_BITS-1:0]      rd_ptr;
  logic [OUT_CNT_BITS-1:0]      count;
  logic                         out_full;
  logic                         rd_en;

  assign out_full = (count == OUT_CNT_BITS'(OUT_DEPTH));
  assign empty    = (count == '0);
  assign pixel    = out_q[rd_ptr];
  assign rd_en    = pop && !empty;

  // Canvas test and Bresenham step decision for the current point.
  always_comb begin
    on_canvas = !cur_x[COORD_BITS-1] && !cur_y[COORD_BITS-1]
           && ($unsigned(cur_x) < {{(COORD_BITS-DIM_BITS){1'b0}}, canvas.width})
           && ($unsigned(cur_y) < {{(COORD_BITS-DIM_BITS){1'b0}}, canvas.height});
    at_end  = (cur_x == end_x) && (cur_y == end_y);
    e2      = {err, 1'b0};
    dx_e    = $signed({3'b000, abs_dx});
    dy_e    = $signed({3'b000, abs_dy});
    move_x  = (e2 > -dy_e);
    move_y  = (e2 < dx_e);
    err_sum = {err[ERR_BITS-1], err}
            - (move_x ? dy_e : '0)
            + (move_y ? dx_e : '0);
  end

  always_comb begin
    state_next = state;
    job_take   = 1'b0;
    do_load    = 1'b0;
    do_step    = 1'b0;
    held_set   = 1'b0;
    held_clear = 1'b0;
    out_push   = 1'b0;
    out_data   = '{pixel_x: held_x, pixel_y: held_y, last_pixel: 1'b0};
    unique case (state)
      WALK_IDLE: begin
        if (job_valid) begin
          job_take   = 1'b1;
          do_load    = 1'b1;
          state_next = WALK_STEP;
        end
      end
      WALK_STEP: begin
        if (!out_full) begin
          // A new in-canvas point releases the one held before it.
          out_push = on_canvas && held_valid;
          held_set = on_canvas;
          if (at_end) begin
            state_next = WALK_FLUSH;
          end else begin
            do_step = 1'b1;
          end
        end
      end
      WALK_FLUSH: begin
        if (!out_full) begin
          out_push            = held_valid;
          out_data.last_pixel = 1'b1;
          held_clear          = 1'b1;
          state_next          = WALK_IDLE;
        end
      end
      default: begin
        state_next = WALK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= WALK_IDLE;
      held_valid <= 1'b0;
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      count      <= '0;
    end else begin
      state <= state_next;
      if (held_clear) begin
        held_valid <= 1'b0;
      end else if (held_set) begin
        held_valid <= 1'b1;
      end
      if (out_push) begin
        wr_ptr <= wr_ptr + OUT_PTR_BITS'(1);
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + OUT_PTR_BITS'(1);
      end
      count <= count + OUT_CNT_BITS'(out_push) - OUT_CNT_BITS'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (do_load) begin
      cur_x  <= job.start_x;
      cur_y  <= job.start_y;
      end_x  <= job.end_x;
      end_y  <= job.end_y;
      abs_dx <= job.abs_dx;
      abs_dy <= job.abs_dy;
      x_down <= job.x_down;
      y_down <= job.y_down;
      err    <= job.err;
    end else if (do_step) begin
      if (move_x) begin
        cur_x <= x_down ? cur_x - COORD_BITS'(1) : cur_x + COORD_BITS'(1);
      end
      if (move_y) begin
        cur_y <= y_down ? cur_y - COORD_BITS'(1) : cur_y + COORD_BITS'(1);
      end
      err <= err_sum[ERR_BITS-1:0];
    end
    if (held_set) begin
      held_x <= cur_x[PIX_BITS-1:0];
      held_y <= cur_y[PIX_BITS-1:0];
    end
    if (out_push) begin
      out_q[wr_ptr] <= out_data;
    end
  end

endmodule

// ===== rtl/core/line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer
// Bresenham line walker that turns line commands into in-canvas pixels.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake               Payload       Direction
//  -------   ---------------------   -----------   ---------
//  command   push / full             line_cmd_t    in
//  pixel     pop / empty             pixel_t       out
//  config    cfg_we (no wait)        cfg_index,    in
//                                    cfg_data
//
//  In the walker a line is handled in order: the job is loaded, each visited
//  point is handled by the single Bresenham step of the walker, and the final
//  pixel is released.
//  Reset (rst, synchronous) empties both queues, returns the walker to idle
//  and loads the canvas registers with 60 columns and 30 rows.
//  A two-entry job queue lets commands transfer while a line is still being
//  walked; a four-entry result queue lets the walker run while the consumer
//  stalls, and the walker pauses only when that queue is full.
//
// The front end classifies each command (spans, step directions, initial
// error term) in the cycle it is accepted. The back end walks the points,
// keeping one in-canvas pixel in hand so that the final one can carry the
// last_pixel flag; points off the canvas are simply skipped, so a command
// may produce no pixels at all.
module line_rasterizer import lras_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  line_cmd_t               command,
  output logic                    empty,
  input  logic                    pop,
  output pixel_t                  pixel,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [DIM_BITS-1:0]     cfg_data
);

  logic [DIM_BITS-1:0] canvas_width;
  logic [DIM_BITS-1:0] canvas_height;
  canvas_t             canvas;
  logic                job_valid;
  logic                job_take;
  walk_job_t           job;

  // Canvas registers; they must be written only while no line is in flight, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= WIDTH_RESET;
      canvas_height <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CANVAS_WIDTH:  canvas_width  <= cfg_data;
        REG_CANVAS_HEIGHT: canvas_height <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Pixel coordinates are six bits wide, so a larger canvas behaves as the
  // largest one that they can address.
  always_comb begin
    canvas.width  = (canvas_width  > CANVAS_MAX) ? CANVAS_MAX : canvas_width;
    canvas.height = (canvas_height > CANVAS_MAX) ? CANVAS_MAX : canvas_height;
  end

  lras_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .command   (command),
    .job_valid (job_valid),
    .job_take  (job_take),
    .job       (job)
  );

  lras_walker u_walker (
    .clk       (clk),
    .rst       (rst),
    .canvas    (canvas),
    .job_valid (job_valid),
    .job_take  (job_take),
    .job       (job),
    .empty     (empty),
    .pop       (pop),
    .pixel     (pixel)
  );

endmodule

// ===== rtl/core/lras_checker.sv =====
// ----------------------------------------------------------------------------
// Line rasterizer port checker
// Watches the ports of the rasterizer for queue behaviour over time.
// ----------------------------------------------------------------------------
`include "line_rasterizer_defines.svh"

module lras_checker import lras_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    push,
  input logic                    full,
  input logic                    empty,
  input logic                    pop,
  input pixel_t                  pixel
);

  // Reset leaves both queues empty.
  `LRAS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> (empty && !full), "queues not empty after reset")

  // The job queue only fills because a command was transferred.
  `LRAS_ASSERT(a_full_by_push, clk, rst, $rose(full) |-> $past(push), "full rose without a push")

  // The result queue only drains because a pixel was transferred.
  `LRAS_ASSERT(a_empty_by_pop, clk, rst, $rose(empty) |-> $past(pop), "empty rose without a pop")

  // A waiting pixel stays put until it is taken.
  `LRAS_ASSERT(a_pixel_held, clk, rst, (!empty && !pop) |=> (!empty && $stable(pixel)), "pending pixel changed")

endmodule

bind line_rasterizer lras_checker u_lras_checker (.*);
